// File: rtl/fdct_pkg.sv
// ----------------------------------------------------------------------------
// fdct_pkg
// Shared types, sequencer states and the cosine basis table for the 8x8
// forward DCT.
// ----------------------------------------------------------------------------
package fdct_pkg;

	localparam int unsigned COEF_FRAC_BITS_DEF = 14;

	// cos(m*pi/16) in unsigned Q32, m = 0..8
	localparam logic [32:0] COS_Q32 [9] = '{
		33'd4294967296, 33'd4212440704, 33'd3968032378, 33'd3571134792,
		33'd3037000500, 33'd2386155981, 33'd1643612827, 33'd837906553,
		33'd0
	};

	typedef enum logic [1:0] {
		ST_FILL,
		ST_ROW,
		ST_COL,
		ST_DRAIN
	} fdct_state_t;

	typedef enum logic {
		PH_ROW,
		PH_COL
	} phase_t;

	// one multiply-accumulate step issued by the sequencer
	typedef struct packed {
		logic       valid;
		phase_t     phase;
		logic       first;
		logic       last;
		logic [5:0] grp;
		logic [2:0] k;
	} issue_t;

	// a finished sum leaving the mac unit
	typedef struct packed {
		logic       valid;
		phase_t     phase;
		logic [5:0] grp;
	} done_t;

	// basis entry c[k][n] with frac fraction bits, rounded half away from zero
	function automatic logic signed [31:0] basis_f(input logic [2:0] k,
		input logic [2:0] n, input int unsigned frac);
		logic [6:0]  prod;
		logic [5:0]  m;
		logic        neg;
		logic [33:0] sum;
		logic [31:0] mag;
		prod = 7'({n, 1'b1}) * 7'(k);
		m    = {1'b0, prod[4:0]};
		neg  = 1'b0;
		if (k == 3'd0) begin
			m = 6'd4;
		end else begin
			if (m > 6'd16) begin
				m = 6'd32 - m;
			end
			if (m > 6'd8) begin
				m   = 6'd16 - m;
				neg = 1'b1;
			end
		end
		sum = 34'(COS_Q32[m[3:0]]) + (34'd1 << (31 - frac));
		mag = 32'(sum >> (32 - frac));
		return neg ? -signed'(mag) : signed'(mag);
	endfunction

endpackage

// File: rtl/fdct_seq.sv
// ----------------------------------------------------------------------------
// fdct_seq
// Sequencer: counts incoming samples, then steps the shared mac through the
// row pass and the column pass, one step per cycle.
// ----------------------------------------------------------------------------
module fdct_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                done_last,
	output logic                busy,
	output logic [5:0]          fill_addr,
	output fdct_pkg::issue_t    issue
);
	import fdct_pkg::*;

	fdct_state_t state_q;
	fdct_state_t state_nxt;
	logic [5:0]  fill_q;
	logic [8:0]  step_q;
	logic        step_end;

	assign step_end  = (step_q == '1);
	assign fill_addr = fill_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_FILL:  if (accept && (fill_q == '1)) state_nxt = ST_ROW;
			ST_ROW:   if (step_end) state_nxt = ST_COL;
			ST_COL:   if (step_end) state_nxt = ST_DRAIN;
			ST_DRAIN: if (done_last) state_nxt = ST_FILL;
			default:  state_nxt = ST_FILL;
		endcase
	end

	always_comb begin
		busy        = 1'b1;
		issue.valid = 1'b0;
		issue.phase = PH_ROW;
		unique case (state_q)
			ST_FILL:  busy = 1'b0;
			ST_ROW:   issue.valid = 1'b1;
			ST_COL: begin
				issue.valid = 1'b1;
				issue.phase = PH_COL;
			end
			ST_DRAIN: busy = 1'b1;
			default:  busy = 1'b1;
		endcase
		issue.grp   = step_q[8:3];
		issue.k     = step_q[2:0];
		issue.first = (step_q[2:0] == 3'd0);
		issue.last  = (step_q[2:0] == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q  <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				fill_q <= fill_q + 6'd1;
			end
			if (issue.valid) begin
				step_q <= step_q + 9'd1;
			end
		end
	end

endmodule

// File: rtl/fdct_mac.sv
// ----------------------------------------------------------------------------
// fdct_mac
// Shared multiply-accumulate unit: registered product, then accumulator
// that restarts on the first step of each eight-term sum.
// ----------------------------------------------------------------------------
module fdct_mac #(
	parameter int unsigned COEF_FRAC_BITS = fdct_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fdct_pkg::issue_t                     tag,
	input  logic signed [COEF_FRAC_BITS+1:0]     coef,
	input  logic signed [COEF_FRAC_BITS+10:0]    data,
	output fdct_pkg::done_t                      done,
	output logic signed [2*COEF_FRAC_BITS+13:0]  acc
);
	import fdct_pkg::*;

	localparam int unsigned CW = COEF_FRAC_BITS + 2;
	localparam int unsigned TW = COEF_FRAC_BITS + 11;
	localparam int unsigned AW = 2 * COEF_FRAC_BITS + 14;

	logic signed [CW+TW-1:0] prod_full;
	logic signed [AW-1:0]    prod_s2;
	issue_t                  tag_s2;
	logic signed [AW-1:0]    acc_q;
	done_t                   done_q;

	assign prod_full = coef * data;

	always_ff @(posedge clk) begin
		// product is one bit narrower than the accumulator: sign-extend
		prod_s2 <= {{(AW-CW-TW){prod_full[CW+TW-1]}}, prod_full};
		if (tag_s2.valid) begin
			acc_q <= tag_s2.first ? prod_s2 : acc_q + prod_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			done_q <= '0;
		end else begin
			tag_s2       <= tag;
			done_q.valid <= tag_s2.valid & tag_s2.last;
			done_q.phase <= tag_s2.phase;
			done_q.grp   <= tag_s2.grp;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

// File: rtl/forward_dct_8x8.sv
// ----------------------------------------------------------------------------
// forward_dct_8x8
// 8x8 two-dimensional DCT-II, row-column form on one shared multiply-
// accumulate unit.
// ----------------------------------------------------------------------------
// usage: drive a sample with start while busy is low; each such beat stores
// one signed 8-bit sample, row-major. busy stays low for the first 63 beats.
// the 64th beat raises busy through the row pass (64 row-transform
// entries, each a sum of 8 terms), the column pass and the pipeline
// drain. the single multiplier does one product a cycle during both
// passes. the column pass produces the 64 coefficients in (u,v)
// row-major order, each on coefficient for exactly one cycle with
// strobe high; last marks the 64th. the receiver cannot hold results
// off, so it must take each strobe beat as it comes. busy falls in the
// cycle after the last coefficient.
// ----------------------------------------------------------------------------
module forward_dct_8x8 #(
	parameter int unsigned COEF_FRAC_BITS = fdct_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [7:0]  sample,
	output logic               strobe,
	output logic signed [12:0] coefficient,
	output logic               last
);
	import fdct_pkg::*;

	localparam int unsigned CW = COEF_FRAC_BITS + 2;       // basis entry
	localparam int unsigned TW = COEF_FRAC_BITS + 11;      // row-pass sum
	localparam int unsigned AW = 2 * COEF_FRAC_BITS + 14;  // column-pass sum
	localparam int unsigned SH = 2 * COEF_FRAC_BITS + 1;   // final scale
	localparam logic [AW-1:0] BIAS = {{(AW-SH){1'b0}}, {SH{1'b1}}};
	localparam logic [5:0] GRP_LAST = '1;

	logic accept;
	logic [5:0] fill_addr;
	issue_t issue;
	logic done_last;

	// pipeline stage 1: memory reads and basis lookup
	issue_t              tag_s1;
	logic signed [CW-1:0] coef_s1;
	logic [7:0]           sample_rd_s1;
	logic signed [TW-1:0] t_rd_s1;
	logic signed [TW-1:0] mac_data;
	logic [2:0]           basis_k;
	logic signed [31:0]   basis_full;

	done_t                done;
	logic signed [AW-1:0] acc;
	logic signed [AW-1:0] acc_adj;

	// sample store and row-transform store
	logic [7:0]           sample_mem [64];
	logic signed [TW-1:0] t_mem [64];

	logic                 strobe_q;
	logic                 last_q;
	logic signed [12:0]   coefficient_q;

	assign accept = start & ~busy;

	fdct_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.done_last (done_last),
		.busy      (busy),
		.fill_addr (fill_addr),
		.issue     (issue)
	);

	// row pass works on c[v][y], column pass on c[u][x]; n is always the step
	assign basis_k    = (issue.phase == PH_ROW) ? issue.grp[2:0] : issue.grp[5:3];
	assign basis_full = basis_f(basis_k, issue.k, COEF_FRAC_BITS);

	// sample store: written on every accepted beat, read s[x][y] in row pass
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_mem[fill_addr] <= sample;
		end
		sample_rd_s1 <= sample_mem[{issue.grp[5:3], issue.k}];
	end

	// row-transform store: t[x][v] written as each row sum finishes,
	// read column-wise in the column pass
	always_ff @(posedge clk) begin
		if (done.valid && (done.phase == PH_ROW)) begin
			t_mem[done.grp] <= acc[TW-1:0];
		end
		t_rd_s1 <= t_mem[{issue.k, issue.grp[2:0]}];
	end

	always_ff @(posedge clk) begin
		coef_s1 <= basis_full[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= issue;
		end
	end

	// samples are sign-extended to the width of the row sums
	assign mac_data = (tag_s1.phase == PH_ROW) ?
		{{(TW-8){sample_rd_s1[7]}}, sample_rd_s1} : t_rd_s1;

	fdct_mac #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.tag    (tag_s1),
		.coef   (coef_s1),
		.data   (mac_data),
		.done   (done),
		.acc    (acc)
	);

	// scale down by 2^SH, truncating toward zero: bias negatives first
	assign acc_adj = acc + (acc[AW-1] ? BIAS : '0);

	always_ff @(posedge clk) begin
		coefficient_q <= acc_adj[SH+12:SH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= done.valid & (done.phase == PH_COL);
			last_q   <= done.valid & (done.phase == PH_COL) & (done.grp == GRP_LAST);
		end
	end

	assign done_last   = last_q;
	assign strobe      = strobe_q;
	assign last        = last_q;
	assign coefficient = coefficient_q;

`ifndef SYNTHESIS
	// results only come out while the block is working on a block
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("coefficient beat while not busy");

	// the final coefficient releases the block in the next cycle
	a_last_release: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !busy)
		else $error("busy held after last coefficient");

	// busy only rises after an accepted sample
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a sample beat");
`endif

endmodule
